[design/tracker_pattern_command_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Tracker pattern command decoder assertion macros
// Concurrent assertion wrappers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TRACKER_PATTERN_COMMAND_DECODER_MACROS_SVH
`define TRACKER_PATTERN_COMMAND_DECODER_MACROS_SVH

`ifndef SYNTHESIS

`define TPCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpcd assertion failed");

`define TPCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpcd assertion failed");

`else

`define TPCD_ASSERT_SAME(label, clk, rst, ante, cons)

`define TPCD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[design/tpcd_pkg.sv]
// ----------------------------------------------------------------------------
// Tracker pattern command decoder package
// Command byte codes, event kinds and the structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcd_pkg;

   localparam int NUM_CHANNELS_DEF = 3;
   localparam int MASK_W = 3;

   localparam logic [7:0] CMD_NOTE_MAX    = 8'h5f;
   localparam logic [7:0] CMD_SAMPLE_BASE = 8'h60;
   localparam logic [7:0] CMD_SAMPLE_MAX  = 8'h6f;
   localparam logic [7:0] CMD_ORN_BASE    = 8'h70;
   localparam logic [7:0] CMD_ORN_MAX     = 8'h7f;
   localparam logic [7:0] CMD_REST        = 8'h80;
   localparam logic [7:0] CMD_EMPTY       = 8'h81;
   localparam logic [7:0] CMD_ORN0        = 8'h82;
   localparam logic [7:0] CMD_ENV_MAX     = 8'h8e;
   localparam logic [7:0] CMD_PERIOD_BASE = 8'ha1;
   localparam logic [7:0] CMD_END         = 8'hff;

   typedef enum logic {
      OP_LINE_START   = 1'b0,
      OP_PATTERN_BYTE = 1'b1
   } opcode_type;

   typedef enum logic [3:0] {
      KIND_NOTE      = 4'd0,
      KIND_SAMPLE    = 4'd1,
      KIND_ORNAMENT  = 4'd2,
      KIND_REST      = 4'd3,
      KIND_EMPTY     = 4'd4,
      KIND_ORN0      = 4'd5,
      KIND_ENVELOPE  = 4'd6,
      KIND_PERIOD    = 4'd7,
      KIND_END       = 4'd8,
      KIND_LINE_MASK = 4'd9
   } event_kind_type;

   typedef struct packed {
      logic       awaiting;
      logic       first_of_line;
      logic [3:0] env_type;
   } chan_sel_type;

   typedef struct packed {
      logic       line_start;
      logic       write;
      logic [1:0] chan;
      logic       clr_first;
      logic       reload;
      logic       set_await;
      logic       clr_await;
      logic [3:0] env_type;
      logic       set_period;
      logic [7:0] period;
   } chan_update_type;

   typedef struct packed {
      event_kind_type    kind;
      logic [1:0]        channel;
      logic [7:0]        value;
      logic [3:0]        env_type;
      logic [7:0]        env_period;
      logic              line_done;
      logic [MASK_W-1:0] need_mask;
   } result_type;

endpackage

`default_nettype wire

[design/tracker_pattern_command_decoder.sv]
// ----------------------------------------------------------------------------
// Tracker pattern command decoder
// Decodes line starts and per-channel command bytes of a tracker pattern.
// ----------------------------------------------------------------------------
// The block takes one beat per cycle while req_tready is high: the beat is
// held in an input register, decoded against the state of its channel, and
// the event lands in a result register that holds it until rsp_tready.
// Envelope commands yield no event and only update channel state; bytes for
// channels beyond the configured count yield no event and change nothing.
// While the result register is full and stalled, one more beat is taken into
// the input register before req_tready drops.
`default_nettype none

`include "tracker_pattern_command_decoder_macros.svh"

module tracker_pattern_command_decoder
   import tpcd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] channel, [9:2] pattern_byte, [15:10] zero
   input  wire logic [15:0] req_tdata,
   // [0] opcode
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [1:0] event_channel, [9:2] event_value, [13:10] envelope_type,
   // [21:14] envelope_period, [22] channel_line_done, [25:23] need_mask,
   // [31:26] zero
   output logic [31:0]      rsp_tdata,
   // [3:0] event_kind
   output logic [3:0]       rsp_tuser
);

   logic                    in_valid_ff;
   logic                    in_valid_in;
   opcode_type              in_opcode_ff;
   logic [1:0]              in_chan_ff;
   logic [7:0]              in_cmd_ff;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   result_type              out_result_ff;
   logic                    out_load;
   logic                    advance;
   logic                    req_take;
   logic                    result_valid;
   result_type              result;
   chan_update_type         update;
   chan_sel_type            sel;
   logic [NUM_CHANNELS-1:0] zero_vec;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = advance && result_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= opcode_type'(req_tuser[0]);
         in_chan_ff   <= req_tdata[1:0];
         in_cmd_ff    <= req_tdata[9:2];
      end
      if (advance && result_valid) begin
         out_result_ff <= result;
      end
   end

   tpcd_channel_bank #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_bank (
      .clock   (clock),
      .reset   (reset),
      .rd_chan (in_chan_ff),
      .update  (update),
      .sel     (sel),
      .zero_vec(zero_vec)
   );

   tpcd_decoder #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_decoder (
      .item_valid  (advance),
      .opcode      (in_opcode_ff),
      .chan        (in_chan_ff),
      .cmd         (in_cmd_ff),
      .sel         (sel),
      .zero_vec    (zero_vec),
      .result_valid(result_valid),
      .result      (result),
      .update      (update)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.kind;
   assign rsp_tdata  = {6'd0, out_result_ff.need_mask, out_result_ff.line_done,
                        out_result_ff.env_period, out_result_ff.env_type,
                        out_result_ff.value, out_result_ff.channel};

   `TPCD_ASSERT_SAME(a_mask_only_on_line, clock, reset, out_valid_ff && (out_result_ff.kind != KIND_LINE_MASK), out_result_ff.need_mask == '0)
   `TPCD_ASSERT_SAME(a_done_on_terminator, clock, reset, out_valid_ff && out_result_ff.line_done, (out_result_ff.kind == KIND_NOTE) || (out_result_ff.kind == KIND_REST) || (out_result_ff.kind == KIND_EMPTY))
   `TPCD_ASSERT_SAME(a_ready_when_empty, clock, reset, !out_valid_ff, req_tready)
   `TPCD_ASSERT_NEXT(a_result_lands, clock, reset, advance && result_valid, out_valid_ff)

endmodule

`default_nettype wire

[design/tpcd_channel_bank.sv]
// ----------------------------------------------------------------------------
// Tracker pattern command decoder channel bank
// Per-channel period, skip counter and envelope registers with their updates.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_channel_bank
   import tpcd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [1:0]              rd_chan,
   input  wire chan_update_type         update,
   output chan_sel_type                 sel,
   output logic [NUM_CHANNELS-1:0]      zero_vec
);

   logic [7:0] period_ff  [NUM_CHANNELS];
   logic [7:0] period_in  [NUM_CHANNELS];
   logic [7:0] counter_ff [NUM_CHANNELS];
   logic [7:0] counter_in [NUM_CHANNELS];
   logic       await_ff   [NUM_CHANNELS];
   logic       await_in   [NUM_CHANNELS];
   logic [3:0] type_ff    [NUM_CHANNELS];
   logic [3:0] type_in    [NUM_CHANNELS];
   logic       first_ff   [NUM_CHANNELS];
   logic       first_in   [NUM_CHANNELS];

   always_comb begin
      sel = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         zero_vec[c] = (counter_ff[c] == 8'd0);
         if (int'(rd_chan) == c) begin
            sel.awaiting      = await_ff[c];
            sel.first_of_line = first_ff[c];
            sel.env_type      = type_ff[c];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         period_in[c]  = period_ff[c];
         counter_in[c] = counter_ff[c];
         await_in[c]   = await_ff[c];
         type_in[c]    = type_ff[c];
         first_in[c]   = first_ff[c];
         if (update.line_start) begin
            if (counter_ff[c] != 8'd0) begin
               counter_in[c] = counter_ff[c] - 8'd1;
               first_in[c]   = 1'b0;
            end else begin
               first_in[c] = 1'b1;
            end
         end else if (update.write && (int'(update.chan) == c)) begin
            if (update.clr_first) begin
               first_in[c] = 1'b0;
            end
            if (update.reload) begin
               counter_in[c] = period_ff[c];
            end
            if (update.clr_await) begin
               await_in[c] = 1'b0;
            end
            if (update.set_await) begin
               await_in[c] = 1'b1;
               type_in[c]  = update.env_type;
            end
            if (update.set_period) begin
               period_in[c] = update.period;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (reset) begin
            period_ff[c]  <= 8'd0;
            counter_ff[c] <= 8'd0;
            await_ff[c]   <= 1'b0;
            type_ff[c]    <= 4'd0;
            first_ff[c]   <= 1'b1;
         end else begin
            period_ff[c]  <= period_in[c];
            counter_ff[c] <= counter_in[c];
            await_ff[c]   <= await_in[c];
            type_ff[c]    <= type_in[c];
            first_ff[c]   <= first_in[c];
         end
      end
   end

endmodule

`default_nettype wire

[design/tpcd_decoder.sv]
// ----------------------------------------------------------------------------
// Tracker pattern command decoder command split
// Turns one item and its channel's state into a result and a state update.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcd_decoder
   import tpcd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
   input  wire logic                    item_valid,
   input  wire opcode_type              opcode,
   input  wire logic [1:0]              chan,
   input  wire logic [7:0]              cmd,
   input  wire chan_sel_type            sel,
   input  wire logic [NUM_CHANNELS-1:0] zero_vec,
   output logic                         result_valid,
   output result_type                   result,
   output chan_update_type              update
);

   localparam int MASK_N = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;

   logic              chan_ok;
   logic [MASK_W-1:0] mask;

   always_comb begin
      mask = '0;
      for (int c = 0; c < MASK_N; c++) begin
         mask[c] = zero_vec[c];
      end
   end

   assign chan_ok = (int'(chan) < NUM_CHANNELS);

   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      result.kind  = KIND_NOTE;
      result.channel = chan;
      update       = '0;
      update.chan  = chan;
      if (item_valid) begin
         if (opcode == OP_LINE_START) begin
            result_valid      = 1'b1;
            result.kind       = KIND_LINE_MASK;
            result.channel    = '0;
            result.need_mask  = mask;
            update.line_start = 1'b1;
         end else if (chan_ok) begin
            if (sel.awaiting) begin
               result_valid      = 1'b1;
               result.kind       = KIND_ENVELOPE;
               result.env_type   = sel.env_type;
               result.env_period = cmd;
               update.write      = 1'b1;
               update.clr_await  = 1'b1;
               update.clr_first  = 1'b1;
            end else if ((chan == '0) && sel.first_of_line && (cmd == CMD_END)) begin
               result_valid = 1'b1;
               result.kind  = KIND_END;
            end else begin
               result_valid     = 1'b1;
               update.write     = 1'b1;
               update.clr_first = 1'b1;
               if (cmd inside {[8'h00:CMD_NOTE_MAX]}) begin
                  result.kind      = KIND_NOTE;
                  result.value     = cmd;
                  result.line_done = 1'b1;
                  update.reload    = 1'b1;
               end else if (cmd inside {[CMD_SAMPLE_BASE:CMD_SAMPLE_MAX]}) begin
                  result.kind  = KIND_SAMPLE;
                  result.value = cmd - CMD_SAMPLE_BASE;
               end else if (cmd inside {[CMD_ORN_BASE:CMD_ORN_MAX]}) begin
                  result.kind  = KIND_ORNAMENT;
                  result.value = cmd - CMD_ORN_BASE;
               end else if (cmd == CMD_REST) begin
                  result.kind      = KIND_REST;
                  result.line_done = 1'b1;
                  update.reload    = 1'b1;
               end else if (cmd == CMD_EMPTY) begin
                  result.kind      = KIND_EMPTY;
                  result.line_done = 1'b1;
                  update.reload    = 1'b1;
               end else if (cmd == CMD_ORN0) begin
                  result.kind = KIND_ORN0;
               end else if (cmd inside {[CMD_ORN0:CMD_ENV_MAX]}) begin
                  result_valid     = 1'b0;
                  update.set_await = 1'b1;
                  update.env_type  = cmd[3:0];
               end else begin
                  result.kind       = KIND_PERIOD;
                  result.value      = cmd - CMD_PERIOD_BASE;
                  update.set_period = 1'b1;
                  update.period     = cmd - CMD_PERIOD_BASE;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire
